// File: sv/timer_expiry_queue_core_macros.svh
// Assertion macros shared by the timer expiry queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TIMER_EXPIRY_QUEUE_CORE_MACROS_SVH
`define TIMER_EXPIRY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("teq: same-cycle check failed");
`define TEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("teq: next-cycle check failed");
`else
`define TEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TEQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/teq_pkg.sv
// Shared constants, types and helpers for the timer expiry queue.
// No dependencies; used by every other file of the block but the assertion macros.
`timescale 1ns / 1ps
package teq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;

  localparam int CMD_W        = 2;
  localparam int TIMEOUT_W    = 32;
  localparam int HANDLE_W     = 4;
  localparam int KIND_W       = 3;
  localparam int SLOT_FIELD_W = 4;
  localparam int NEAR_W       = 32;

  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int TREE_LEVELS = $clog2(TIMER_SLOTS);
  localparam int TREE_NODES  = 1 << TREE_LEVELS;
  localparam int SETTLE_W    = $clog2(TREE_LEVELS + 1);
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [TIMER_SLOTS-1:0]  slot_mask_t;
  typedef logic [HANDLE_W-1:0]     handle_t;
  typedef logic [SLOT_FIELD_W-1:0] slot_field_t;
  typedef logic [NEAR_W-1:0]       near_t;
  typedef logic [SETTLE_W-1:0]     settle_cnt_t;
  typedef logic [COUNT_W-1:0]      count_t;

  localparam near_t NEAR_EMPTY = 32'hFFFF_FFFF;
  localparam near_t NEAR_SAT   = 32'hFFFF_FFFE;
  localparam time_t NEAR_LIMIT = time_t'(64'h0000_0000_FFFF_FFFF);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  typedef enum logic [KIND_W-1:0] {
    EV_ADDED    = 3'd0,
    EV_BAD      = 3'd1,
    EV_FULL     = 3'd2,
    EV_DELETED  = 3'd3,
    EV_NOTFOUND = 3'd4,
    EV_EXPIRED  = 3'd5,
    EV_IDLE     = 3'd6
  } event_t;

  typedef struct packed {
    logic  vld;
    slot_t idx;
    time_t tm;
  } node_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic take_root;
    logic set_quiet;
    logic load_out;
    logic last;
  } teq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_code_t command;
    logic      due;
  } teq_status_t;

  // Earlier expiry wins; on a tie the left (lower slot) side wins.
  function automatic node_t min_node(node_t a, node_t b);
    return (!b.vld || (a.vld && a.tm <= b.tm)) ? a : b;
  endfunction

endpackage

// File: sv/teq_req_if.sv
// Command channel of the timer expiry queue: valid/ready plus request payload.
// Depends on teq_pkg for field widths.
`timescale 1ns / 1ps
interface teq_req_if;
  logic                                valid;
  logic                                ready;
  logic [teq_pkg::CMD_W-1:0]           command;
  logic signed [teq_pkg::TIMEOUT_W-1:0] timeout_ms;
  logic [teq_pkg::HANDLE_W-1:0]        handle;

  modport source (output valid, command, timeout_ms, handle, input ready);
  modport sink (input valid, command, timeout_ms, handle, output ready);
endinterface

// File: sv/teq_rsp_if.sv
// Result channel of the timer expiry queue: valid/ready plus event payload.
// Depends on teq_pkg for field widths.
`timescale 1ns / 1ps
interface teq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [teq_pkg::KIND_W-1:0]       event_kind;
  logic [teq_pkg::SLOT_FIELD_W-1:0] slot;
  logic [teq_pkg::NEAR_W-1:0]       nearest_timeout;
  logic                             last;

  modport source (output valid, event_kind, slot, nearest_timeout, last, input ready);
  modport sink (input valid, event_kind, slot, nearest_timeout, last, output ready);
endinterface

// File: sv/teq_min_tree.sv
// Registered comparator tree: finds the earliest valid expiry, lowest slot on ties.
// Depends on teq_pkg. One register level per tree level.
`timescale 1ns / 1ps
module teq_min_tree (
  input  logic                clk,
  input  logic                rst,
  input  teq_pkg::slot_mask_t valid,
  input  teq_pkg::time_t      expiry [teq_pkg::TIMER_SLOTS],
  output teq_pkg::node_t      root
);

  teq_pkg::node_t leaf [teq_pkg::TREE_NODES];
  teq_pkg::node_t node [1:teq_pkg::TREE_NODES-1];

  for (genvar i = 0; i < teq_pkg::TREE_NODES; i++) begin : g_leaf
    if (i < teq_pkg::TIMER_SLOTS) begin : g_used
      assign leaf[i] = '{vld: valid[i], idx: teq_pkg::slot_t'(i), tm: expiry[i]};
    end else begin : g_pad
      assign leaf[i] = '{vld: 1'b0, idx: teq_pkg::slot_t'(0), tm: '0};
    end
  end

  // node k has children 2k and 2k+1; the bottom row reads the leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k < teq_pkg::TREE_NODES; k++) begin
        node[k].vld <= 1'b0;
      end
    end else begin
      for (int k = 1; k < teq_pkg::TREE_NODES; k++) begin
        if (2 * k >= teq_pkg::TREE_NODES) begin
          node[k] <= teq_pkg::min_node(leaf[2*k - teq_pkg::TREE_NODES],
                                       leaf[2*k + 1 - teq_pkg::TREE_NODES]);
        end else begin
          node[k] <= teq_pkg::min_node(node[2*k], node[2*k + 1]);
        end
      end
    end
  end

  assign root = node[1];

endmodule

// File: sv/teq_datapath.sv
// Timer table, millisecond counter, distance register and result register.
// Depends on teq_pkg and teq_min_tree; driven by teq_ctrl through teq_cmd_t.
`timescale 1ns / 1ps
module teq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  teq_pkg::teq_cmd_t            cmd,
  output teq_pkg::teq_status_t         status,
  input  logic [teq_pkg::CMD_W-1:0]    req_command,
  input  logic signed [teq_pkg::TIMEOUT_W-1:0] req_timeout_ms,
  input  teq_pkg::handle_t             req_handle,
  output logic [teq_pkg::KIND_W-1:0]   out_kind,
  output teq_pkg::slot_field_t         out_slot,
  output teq_pkg::near_t               out_near,
  output logic                         out_last
);

  teq_pkg::cmd_code_t                   req_cmd;
  logic signed [teq_pkg::TIMEOUT_W-1:0] req_timeout;
  teq_pkg::handle_t                     req_hdl;

  teq_pkg::slot_mask_t  valid;
  teq_pkg::time_t       expiry [teq_pkg::TIMER_SLOTS];
  teq_pkg::time_t       current_time;
  teq_pkg::event_t      pend_kind;
  teq_pkg::slot_field_t pend_slot;
  teq_pkg::near_t       near;
  teq_pkg::near_t       near_next;
  teq_pkg::node_t       root;

  logic                        full;
  teq_pkg::slot_t              free_idx;
  logic                        timeout_ok;
  logic                        handle_hit;
  logic [teq_pkg::TIME_BITS:0] gap;

  teq_min_tree u_tree (
    .clk    (clk),
    .rst    (rst),
    .valid  (valid),
    .expiry (expiry),
    .root   (root)
  );

  always_comb begin
    full     = &valid;
    free_idx = '0;
    for (int i = teq_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = teq_pkg::slot_t'(i);
    end
  end

  assign timeout_ok = (req_timeout > 32'sd0);
  assign handle_hit = (32'(req_hdl) < 32'(teq_pkg::TIMER_SLOTS)) &&
                      valid[teq_pkg::slot_t'(req_hdl)];

  // borrow out of the subtract means the earliest expiry is already due
  assign gap = {1'b0, root.tm} - {1'b0, current_time};

  always_comb begin
    if (!root.vld) begin
      near_next = teq_pkg::NEAR_EMPTY;
    end else if (gap[teq_pkg::TIME_BITS] || gap[teq_pkg::TIME_BITS-1:0] == '0) begin
      near_next = '0;
    end else if (gap[teq_pkg::TIME_BITS-1:0] >= teq_pkg::NEAR_LIMIT) begin
      near_next = teq_pkg::NEAR_SAT;
    end else begin
      near_next = teq_pkg::near_t'(gap[teq_pkg::TIME_BITS-1:0]);
    end
  end

  assign status.command = req_cmd;
  assign status.due     = (near == '0);

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      current_time <= '0;
    end else begin
      if (cmd.exec) begin
        case (req_cmd)
          teq_pkg::CMD_ADD: begin
            if (timeout_ok && !full) valid[free_idx] <= 1'b1;
          end
          teq_pkg::CMD_DELETE: begin
            if (handle_hit) valid[teq_pkg::slot_t'(req_hdl)] <= 1'b0;
          end
          teq_pkg::CMD_TICK: begin
            current_time <= current_time + teq_pkg::time_t'(1);
          end
          default: ;
        endcase
      end
      if (cmd.take_root) valid[root.idx] <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    near <= near_next;
    if (cmd.latch_in) begin
      req_cmd     <= teq_pkg::cmd_code_t'(req_command);
      req_timeout <= req_timeout_ms;
      req_hdl     <= req_handle;
    end
    if (cmd.exec) begin
      case (req_cmd)
        teq_pkg::CMD_ADD: begin
          if (!timeout_ok) begin
            pend_kind <= teq_pkg::EV_BAD;
            pend_slot <= '0;
          end else if (full) begin
            pend_kind <= teq_pkg::EV_FULL;
            pend_slot <= '0;
          end else begin
            pend_kind        <= teq_pkg::EV_ADDED;
            pend_slot        <= teq_pkg::slot_field_t'(free_idx);
            expiry[free_idx] <= current_time + teq_pkg::time_t'($unsigned(req_timeout));
          end
        end
        teq_pkg::CMD_DELETE: begin
          pend_kind <= handle_hit ? teq_pkg::EV_DELETED : teq_pkg::EV_NOTFOUND;
          pend_slot <= req_hdl;
        end
        default: ;
      endcase
    end
    if (cmd.take_root) begin
      pend_kind <= teq_pkg::EV_EXPIRED;
      pend_slot <= teq_pkg::slot_field_t'(root.idx);
    end
    if (cmd.set_quiet) begin
      pend_kind <= teq_pkg::EV_IDLE;
      pend_slot <= '0;
    end
    if (cmd.load_out) begin
      out_kind <= pend_kind;
      out_slot <= pend_slot;
      out_near <= near;
      out_last <= cmd.last;
    end
  end

endmodule

// File: sv/teq_ctrl.sv
// Sequencer of the timer expiry queue: handshakes, settle wait, expiry emission.
// Depends on teq_pkg and the assertion macros; commands teq_datapath.
`timescale 1ns / 1ps
`include "timer_expiry_queue_core_macros.svh"
module teq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  teq_pkg::teq_status_t status,
  output teq_pkg::teq_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SETTLE = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                state;
  teq_pkg::settle_cnt_t  cnt;
  teq_pkg::count_t       n;
  logic                  tick_mode;
  logic                  scan_todo;
  logic                  out_free;
  logic                  last_now;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  // a tick keeps emitting while the next root is due and the cap is not hit
  assign last_now  = !tick_mode || !status.due ||
                     (n == teq_pkg::count_t'(teq_pkg::MAX_RESULTS));

  always_comb begin
    cmd      = '0;
    cmd.last = last_now;
    case (state)
      ST_IDLE: cmd.latch_in = req_valid;
      ST_EXEC: cmd.exec = 1'b1;
      ST_SCAN: begin
        cmd.take_root = status.due;
        cmd.set_quiet = !status.due;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          cmd.take_root = !last_now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      n         <= '0;
      tick_mode <= 1'b0;
      scan_todo <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status.command == teq_pkg::CMD_NONE) begin
            state <= ST_IDLE;
          end else begin
            tick_mode <= (status.command == teq_pkg::CMD_TICK);
            scan_todo <= (status.command == teq_pkg::CMD_TICK);
            n         <= '0;
            cnt       <= '0;
            state     <= ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          // tree levels plus the distance register
          if (cnt == teq_pkg::settle_cnt_t'(teq_pkg::TREE_LEVELS)) begin
            state <= scan_todo ? ST_SCAN : ST_EMIT;
          end else begin
            cnt <= cnt + teq_pkg::settle_cnt_t'(1);
          end
        end
        ST_SCAN: begin
          scan_todo <= 1'b0;
          if (status.due) begin
            n     <= teq_pkg::count_t'(1);
            cnt   <= '0;
            state <= ST_SETTLE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last_now) begin
              state <= ST_IDLE;
            end else begin
              n     <= n + teq_pkg::count_t'(1);
              cnt   <= '0;
              state <= ST_SETTLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TEQ_ASSERT_NEXT(a_accept_exec, clk, rst, req_valid && req_ready, state == ST_EXEC)
  `TEQ_ASSERT_IMPLIES(a_take_due, clk, rst, cmd.take_root, status.due)
  `TEQ_ASSERT_IMPLIES(a_more_tick, clk, rst, cmd.load_out && !cmd.last, tick_mode && n < teq_pkg::count_t'(teq_pkg::MAX_RESULTS))
  `TEQ_ASSERT_IMPLIES(a_load_free, clk, rst, cmd.load_out, !rsp_valid || rsp_ready)

endmodule

// File: sv/timer_expiry_queue_core.sv
// Top level of the timer expiry queue: controller plus datapath on two channels.
// Depends on teq_pkg, teq_req_if, teq_rsp_if, teq_ctrl and teq_datapath.
`timescale 1ns / 1ps
// One-shot timer table of TIMER_SLOTS entries kept as absolute expiry times against
// a millisecond counter. Commands on req: add (returns the lowest free slot), delete,
// and tick (advance one millisecond, then emit due timers earliest first, lower slot on
// ties, at most MAX_RESULTS per tick). Each result beat carries the distance to the
// nearest remaining expiry (all ones when empty) and last marks the final beat of a
// command. Each result waits for the registered min tree, log2(TIMER_SLOTS) levels deep,
// and one distance register to settle, and every further expiration of a tick waits
// for the tree to settle again after the previous root is taken.
// The next command is accepted once the final result is in the output register,
// even if rsp has not taken it yet.
module timer_expiry_queue_core (
  input logic        clk,
  input logic        rst,
  teq_req_if.sink    req,
  teq_rsp_if.source  rsp
);

  teq_pkg::teq_cmd_t    cmd;
  teq_pkg::teq_status_t status;
  logic                 rsp_valid;
  logic [teq_pkg::KIND_W-1:0] out_kind;
  teq_pkg::slot_field_t out_slot;
  teq_pkg::near_t       out_near;
  logic                 out_last;
  logic                 req_ready;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  teq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_command    (req.command),
    .req_timeout_ms (req.timeout_ms),
    .req_handle     (req.handle),
    .out_kind       (out_kind),
    .out_slot       (out_slot),
    .out_near       (out_near),
    .out_last       (out_last)
  );

  assign req.ready           = req_ready;
  assign rsp.valid           = rsp_valid;
  assign rsp.event_kind      = out_kind;
  assign rsp.slot            = out_slot;
  assign rsp.nearest_timeout = out_near;
  assign rsp.last            = out_last;

endmodule
